>>> src/pid_controller_step_top_assert.svh
// Assertion macros shared by the PID step RTL.
// Included by files that check their own control logic; no other dependencies.
`ifndef PID_CONTROLLER_STEP_TOP_ASSERT_SVH
`define PID_CONTROLLER_STEP_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PIDC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pidc assertion failed");
`define PIDC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pidc assertion failed");
`else
`define PIDC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define PIDC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> src/pidc_pkg.sv
// Shared types and constants of the PID step block.
// No dependencies; used by the register block, the arithmetic unit, the top level and the testbench.
package pidc_pkg;

    // Multiplier bits consumed per cycle by the shared arithmetic unit.
    localparam int MUL_DIGIT_W = 4;
    localparam int REG_IDX_W   = 3;

    typedef enum logic [1:0] {
        KIND_UPD_CALC = 2'd0,
        KIND_UPD_RATE = 2'd1,
        KIND_CLEAR    = 2'd2,
        KIND_NONE     = 2'd3
    } t_kind;

    typedef enum logic {
        MDU_MUL = 1'b0,
        MDU_DIV = 1'b1
    } t_mdu_op;

    typedef struct packed {
        logic    start;
        t_mdu_op op;
        logic    neg;
    } t_mdu_ctl;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PROP_GAIN  = 3'd0,
        REG_INTEG_GAIN = 3'd1,
        REG_DERIV_GAIN = 3'd2,
        REG_INTEG_MAX  = 3'd3,
        REG_INTEG_MIN  = 3'd4
    } t_reg_idx;

endpackage

>>> src/pidc_in_if.sv
// Input item channel of the PID step block: valid/ready plus the item fields.
// No dependencies.
interface pidc_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   kind;
    logic signed [DATA_WIDTH-1:0] error_in;
    logic signed [DATA_WIDTH-1:0] error_rate;
    logic [DATA_WIDTH-1:0]        time_step;
    logic                         input_invalid;

    modport source (
        output valid, kind, error_in, error_rate, time_step, input_invalid,
        input  ready
    );
    modport sink (
        input  valid, kind, error_in, error_rate, time_step, input_invalid,
        output ready
    );
endinterface

>>> src/pidc_out_if.sv
// Result item channel of the PID step block: valid/ready plus the result fields.
// No dependencies.
interface pidc_out_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] command;
    logic signed [DATA_WIDTH-1:0] prop_error;
    logic signed [DATA_WIDTH-1:0] integ_error;
    logic signed [DATA_WIDTH-1:0] deriv_error;

    modport source (
        output valid, command, prop_error, integ_error, deriv_error,
        input  ready
    );
    modport sink (
        input  valid, command, prop_error, integ_error, deriv_error,
        output ready
    );
endinterface

>>> src/pidc_mdu.sv
// Shared sign-magnitude multiply / divide unit of the PID step block.
// Depends on pidc_pkg for the control struct and the multiplier digit width.
module pidc_mdu #(
    parameter int  DATA_WIDTH = 32,
    parameter int  FRAC_BITS  = 16,
    localparam int MUL_RES_W  = 2 * DATA_WIDTH + 1 - FRAC_BITS,
    localparam int NUM_W      = DATA_WIDTH + FRAC_BITS + 1,
    localparam int RES_W      = (MUL_RES_W > NUM_W + 1) ? MUL_RES_W : NUM_W + 1
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  pidc_pkg::t_mdu_ctl      i_ctl,
    input  logic [DATA_WIDTH:0]     i_opa,
    input  logic [DATA_WIDTH-1:0]   i_opb,
    output logic                    o_done,
    output logic signed [RES_W-1:0] o_res
);
    localparam int W     = DATA_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int MB    = pidc_pkg::MUL_DIGIT_W;
    localparam int STEPS = (W + MB - 1) / MB;
    localparam int SM    = STEPS * MB;
    localparam int LW    = (SM > NUM_W) ? SM : NUM_W;
    localparam int HW    = W + MB;
    localparam int CW    = $clog2(LW);

    typedef enum logic [1:0] {
        M_IDLE,
        M_RUN,
        M_FIN
    } t_mstate;

    t_mstate             r_state, n_state;
    logic [CW-1:0]       r_cnt, n_cnt;
    pidc_pkg::t_mdu_op   r_op, n_op;
    logic                r_neg, n_neg;
    logic [HW-1:0]       r_hi, n_hi;
    logic [LW-1:0]       r_lo, n_lo;
    logic [W-1:0]        r_mcand, n_mcand;
    logic signed [RES_W-1:0] r_res, n_res;
    logic                r_done, n_done;

    logic [MB-1:0]       digit;
    logic [HW-1:0]       mul_sum;
    logic [W:0]          rem2;
    logic [W+1:0]        sub;
    logic                ge;
    logic [HW+SM-1:0]    prod_full;
    logic signed [2*W:0] mul_s;
    logic signed [MUL_RES_W-1:0] mul_part;
    logic signed [NUM_W:0]       div_s;

    always_comb begin
        // Multiply: add one digit's partial product into the high half, then shift right.
        digit   = r_lo[MB-1:0];
        mul_sum = r_hi + HW'(r_mcand) * HW'(digit);
        // Divide: restoring step with the next numerator bit shifted into the remainder.
        rem2    = {r_hi[W-1:0], r_lo[NUM_W-1]};
        sub     = {1'b0, rem2} - {2'b00, r_mcand};
        ge      = !sub[W+1];

        prod_full = {r_hi, r_lo[SM-1:0]};
        mul_s     = $signed({1'b0, prod_full[2*W-1:0]});
        if (r_neg) begin
            mul_s = -mul_s;
        end
        mul_part  = mul_s[2*W:F];
        div_s     = $signed({1'b0, r_lo[NUM_W-1:0]});
        if (r_neg) begin
            div_s = -div_s;
        end

        n_state = r_state;
        n_cnt   = r_cnt;
        n_op    = r_op;
        n_neg   = r_neg;
        n_hi    = r_hi;
        n_lo    = r_lo;
        n_mcand = r_mcand;
        n_res   = r_res;
        n_done  = 1'b0;

        unique case (r_state)
            M_IDLE: begin
                if (i_ctl.start) begin
                    n_op    = i_ctl.op;
                    n_neg   = i_ctl.neg;
                    n_mcand = i_opb;
                    n_hi    = '0;
                    n_state = M_RUN;
                    if (i_ctl.op == pidc_pkg::MDU_MUL) begin
                        n_lo  = LW'(i_opa[W-1:0]);
                        n_cnt = CW'(STEPS - 1);
                    end else begin
                        n_lo  = LW'({i_opa, {F{1'b0}}});
                        n_cnt = CW'(NUM_W - 1);
                    end
                end
            end
            M_RUN: begin
                if (r_op == pidc_pkg::MDU_MUL) begin
                    n_hi             = mul_sum >> MB;
                    n_lo             = r_lo >> MB;
                    n_lo[SM-1 -: MB] = mul_sum[MB-1:0];
                end else begin
                    n_hi = HW'(ge ? sub[W:0] : rem2);
                    n_lo = {r_lo[LW-2:0], ge};
                end
                if (r_cnt == '0) begin
                    n_state = M_FIN;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            M_FIN: begin
                n_res   = (r_op == pidc_pkg::MDU_MUL) ? RES_W'(mul_part) : RES_W'(div_s);
                n_done  = 1'b1;
                n_state = M_IDLE;
            end
            default: begin
                n_state = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
        r_cnt   <= n_cnt;
        r_op    <= n_op;
        r_neg   <= n_neg;
        r_hi    <= n_hi;
        r_lo    <= n_lo;
        r_mcand <= n_mcand;
        r_res   <= n_res;
    end

    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

>>> src/pidc_regs.sv
// APB-style configuration registers of the PID step block (gains and clamp limits).
// Depends on pidc_pkg for the register index codes.
module pidc_regs #(
    parameter int  DATA_WIDTH = 32,
    localparam int PDATA_W    = (DATA_WIDTH > 32) ? 64 : 32,
    localparam int PADDR_W    = (DATA_WIDTH > 32) ? 6 : 5
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [PADDR_W-1:0]           paddr,
    input  logic [PDATA_W-1:0]           pwdata,
    output logic [PDATA_W-1:0]           prdata,
    output logic                         pready,
    output logic signed [DATA_WIDTH-1:0] o_prop_gain,
    output logic signed [DATA_WIDTH-1:0] o_integ_gain,
    output logic signed [DATA_WIDTH-1:0] o_deriv_gain,
    output logic signed [DATA_WIDTH-1:0] o_integ_max,
    output logic signed [DATA_WIDTH-1:0] o_integ_min
);
    localparam int ADDR_LSB = PADDR_W - pidc_pkg::REG_IDX_W;

    logic signed [DATA_WIDTH-1:0] r_prop_gain, r_integ_gain, r_deriv_gain;
    logic signed [DATA_WIDTH-1:0] r_integ_max, r_integ_min;
    pidc_pkg::t_reg_idx           idx;
    logic                         wr_en;

    assign idx    = pidc_pkg::t_reg_idx'(paddr[PADDR_W-1:ADDR_LSB]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain  <= '0;
            r_integ_gain <= '0;
            r_deriv_gain <= '0;
            r_integ_max  <= '0;
            r_integ_min  <= '0;
        end else if (wr_en) begin
            unique case (idx)
                pidc_pkg::REG_PROP_GAIN:  r_prop_gain  <= pwdata[DATA_WIDTH-1:0];
                pidc_pkg::REG_INTEG_GAIN: r_integ_gain <= pwdata[DATA_WIDTH-1:0];
                pidc_pkg::REG_DERIV_GAIN: r_deriv_gain <= pwdata[DATA_WIDTH-1:0];
                pidc_pkg::REG_INTEG_MAX:  r_integ_max  <= pwdata[DATA_WIDTH-1:0];
                pidc_pkg::REG_INTEG_MIN:  r_integ_min  <= pwdata[DATA_WIDTH-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            pidc_pkg::REG_PROP_GAIN:  prdata = PDATA_W'(r_prop_gain);
            pidc_pkg::REG_INTEG_GAIN: prdata = PDATA_W'(r_integ_gain);
            pidc_pkg::REG_DERIV_GAIN: prdata = PDATA_W'(r_deriv_gain);
            pidc_pkg::REG_INTEG_MAX:  prdata = PDATA_W'(r_integ_max);
            pidc_pkg::REG_INTEG_MIN:  prdata = PDATA_W'(r_integ_min);
            default:                  prdata = '0;
        endcase
    end

    assign o_prop_gain  = r_prop_gain;
    assign o_integ_gain = r_integ_gain;
    assign o_deriv_gain = r_deriv_gain;
    assign o_integ_max  = r_integ_max;
    assign o_integ_min  = r_integ_min;

endmodule

>>> src/pid_controller_step_top.sv
// Top level of the PID step block: item sequencer, controller state and output register.
// Depends on pidc_pkg, pidc_in_if, pidc_out_if, pidc_mdu, pidc_regs and the assertion header.

// One PID step per item in signed fixed point (FRAC_BITS fraction bits). All products and
// quotients go through a single shared unit that multiplies four bits per cycle and divides
// one quotient bit per cycle; the sequencer runs them one after another, so the block takes
// one item at a time. An update with a supplied derivative runs four multiplies; an update
// that forms the derivative adds one divide; an integral clamp with nonzero integral gain
// adds one more divide. Clear items, unused kinds and suppressed updates (zero time step or
// invalid input) skip the arithmetic unit and go straight to the output step. A finished
// result waits in an output register, and the next item is taken while it waits.
`include "pid_controller_step_top_assert.svh"

module pid_controller_step_top #(
    parameter int  DATA_WIDTH = 32,
    parameter int  FRAC_BITS  = 16,
    localparam int PDATA_W    = (DATA_WIDTH > 32) ? 64 : 32,
    localparam int PADDR_W    = (DATA_WIDTH > 32) ? 6 : 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pidc_in_if.sink            i_in,
    pidc_out_if.source         o_out,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);
    localparam int W         = DATA_WIDTH;
    localparam int MUL_RES_W = 2 * DATA_WIDTH + 1 - FRAC_BITS;
    localparam int NUM_W     = DATA_WIDTH + FRAC_BITS + 1;
    localparam int RES_W     = (MUL_RES_W > NUM_W + 1) ? MUL_RES_W : NUM_W + 1;
    localparam int SUM_W     = RES_W + 3;

    localparam logic signed [W-1:0] MAX_VAL = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] MIN_VAL = {1'b1, {(W-1){1'b0}}};

    typedef enum logic [3:0] {
        S_IDLE,
        S_PMUL,
        S_IINC,
        S_IMUL,
        S_CDIV,
        S_DDIV,
        S_DMUL,
        S_CMD,
        S_DONE
    } t_state;

    function automatic logic signed [W-1:0] f_sat(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] hi_lim;
        logic signed [SUM_W-1:0] lo_lim;
        hi_lim = SUM_W'(MAX_VAL);
        lo_lim = SUM_W'(MIN_VAL);
        if (v > hi_lim) begin
            return MAX_VAL;
        end else if (v < lo_lim) begin
            return MIN_VAL;
        end
        return W'(v);
    endfunction

    // Configuration
    logic signed [W-1:0] w_prop_gain, w_integ_gain, w_deriv_gain, w_integ_max, w_integ_min;

    // Sequencer and controller state
    t_state              r_state, n_state;
    pidc_pkg::t_kind     r_kind, n_kind;
    logic signed [W-1:0] r_err, n_err;
    logic [W-1:0]        r_dt, n_dt;
    logic signed [W-1:0] r_integ, n_integ;
    logic signed [W-1:0] r_prev, n_prev;
    logic signed [W-1:0] r_rec, n_rec;
    logic signed [W-1:0] r_deriv, n_deriv;
    logic signed [W-1:0] r_lim, n_lim;
    logic signed [W-1:0] r_cmd, n_cmd;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic                r_start, n_start;
    logic                r_ovalid, n_ovalid;
    logic signed [W-1:0] r_o_cmd, n_o_cmd;
    logic signed [W-1:0] r_o_prop, n_o_prop;
    logic signed [W-1:0] r_o_integ, n_o_integ;
    logic signed [W-1:0] r_o_deriv, n_o_deriv;

    // Arithmetic unit operands and result
    pidc_pkg::t_mdu_op       op;
    logic signed [W:0]       opa_s, opb_s;
    logic [W:0]              opa_mag, opb_full;
    logic [W-1:0]            opb_mag;
    logic                    op_neg;
    pidc_pkg::t_mdu_ctl      mdu_ctl;
    logic                    w_done;
    logic signed [RES_W-1:0] w_res;

    // Clamp selection and the step that follows the integral
    logic                clamp_hit;
    logic signed [W-1:0] clamp_lim;
    logic signed [W-1:0] clamp_back;
    t_state              after_integ;

    pidc_regs #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .o_prop_gain  (w_prop_gain),
        .o_integ_gain (w_integ_gain),
        .o_deriv_gain (w_deriv_gain),
        .o_integ_max  (w_integ_max),
        .o_integ_min  (w_integ_min)
    );

    pidc_mdu #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_mdu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mdu_ctl),
        .i_opa   (opa_mag),
        .i_opb   (opb_mag),
        .o_done  (w_done),
        .o_res   (w_res)
    );

    // Operands are chosen by the step in flight; the unit samples them on its start cycle.
    always_comb begin
        op    = pidc_pkg::MDU_MUL;
        opa_s = '0;
        opb_s = '0;
        unique case (r_state)
            S_PMUL: begin
                opa_s = (W+1)'(r_err);
                opb_s = (W+1)'(w_prop_gain);
            end
            S_IINC: begin
                opa_s = (W+1)'(r_err);
                opb_s = $signed({1'b0, r_dt});
            end
            S_IMUL: begin
                opa_s = (W+1)'(r_integ);
                opb_s = (W+1)'(w_integ_gain);
            end
            S_CDIV: begin
                op    = pidc_pkg::MDU_DIV;
                opa_s = (W+1)'(r_lim);
                opb_s = (W+1)'(w_integ_gain);
            end
            S_DDIV: begin
                op    = pidc_pkg::MDU_DIV;
                opa_s = (W+1)'(r_err) - (W+1)'(r_prev);
                opb_s = $signed({1'b0, r_dt});
            end
            S_DMUL: begin
                opa_s = (W+1)'(r_deriv);
                opb_s = (W+1)'(w_deriv_gain);
            end
            default: begin
            end
        endcase
        opa_mag  = opa_s[W] ? -opa_s : opa_s;
        opb_full = opb_s[W] ? -opb_s : opb_s;
        opb_mag  = opb_full[W-1:0];
        op_neg   = opa_s[W] ^ opb_s[W];
        mdu_ctl  = '{start: r_start, op: op, neg: op_neg};
    end

    always_comb begin
        // The upper limit wins; the lower one is only tested when the upper holds.
        clamp_hit = 1'b0;
        clamp_lim = w_integ_max;
        if (w_res > RES_W'(w_integ_max)) begin
            clamp_hit = 1'b1;
        end else if (w_res < RES_W'(w_integ_min)) begin
            clamp_hit = 1'b1;
            clamp_lim = w_integ_min;
        end
        // With zero integral gain the integral saturates toward the sign of the limit.
        if (clamp_lim == '0) begin
            clamp_back = '0;
        end else if (clamp_lim[W-1]) begin
            clamp_back = MIN_VAL;
        end else begin
            clamp_back = MAX_VAL;
        end
        after_integ = (r_kind == pidc_pkg::KIND_UPD_CALC) ? S_DDIV : S_DMUL;
    end

    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_err     = r_err;
        n_dt      = r_dt;
        n_integ   = r_integ;
        n_prev    = r_prev;
        n_rec     = r_rec;
        n_deriv   = r_deriv;
        n_lim     = r_lim;
        n_cmd     = r_cmd;
        n_sum     = r_sum;
        n_start   = 1'b0;
        n_ovalid  = r_ovalid;
        n_o_cmd   = r_o_cmd;
        n_o_prop  = r_o_prop;
        n_o_integ = r_o_integ;
        n_o_deriv = r_o_deriv;

        if (o_out.valid && o_out.ready) begin
            n_ovalid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid) begin
                    n_kind  = pidc_pkg::t_kind'(i_in.kind);
                    n_err   = i_in.error_in;
                    n_dt    = i_in.time_step;
                    n_cmd   = '0;
                    n_state = S_DONE;
                    unique case (pidc_pkg::t_kind'(i_in.kind)) inside
                        pidc_pkg::KIND_CLEAR: begin
                            n_integ = '0;
                            n_prev  = '0;
                            n_rec   = '0;
                            n_deriv = '0;
                        end
                        pidc_pkg::KIND_UPD_CALC, pidc_pkg::KIND_UPD_RATE: begin
                            n_rec = i_in.error_in;
                            if (pidc_pkg::t_kind'(i_in.kind) == pidc_pkg::KIND_UPD_RATE) begin
                                n_deriv = i_in.error_rate;
                            end
                            if (i_in.time_step != '0 && !i_in.input_invalid) begin
                                n_state = S_PMUL;
                                n_start = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_PMUL: begin
                if (w_done) begin
                    n_sum   = SUM_W'(w_res);
                    n_state = S_IINC;
                    n_start = 1'b1;
                end
            end
            S_IINC: begin
                if (w_done) begin
                    n_integ = f_sat(SUM_W'(r_integ) + SUM_W'(w_res));
                    n_state = S_IMUL;
                    n_start = 1'b1;
                end
            end
            S_IMUL: begin
                if (w_done) begin
                    n_start = 1'b1;
                    n_state = after_integ;
                    if (clamp_hit) begin
                        n_sum = r_sum + SUM_W'(clamp_lim);
                        n_lim = clamp_lim;
                        if (w_integ_gain == '0) begin
                            n_integ = clamp_back;
                        end else begin
                            n_state = S_CDIV;
                        end
                    end else begin
                        n_sum = r_sum + SUM_W'(w_res);
                    end
                end
            end
            S_CDIV: begin
                if (w_done) begin
                    n_integ = f_sat(SUM_W'(w_res));
                    n_state = after_integ;
                    n_start = 1'b1;
                end
            end
            S_DDIV: begin
                if (w_done) begin
                    n_deriv = f_sat(SUM_W'(w_res));
                    n_prev  = r_err;
                    n_state = S_DMUL;
                    n_start = 1'b1;
                end
            end
            S_DMUL: begin
                if (w_done) begin
                    n_sum   = r_sum + SUM_W'(w_res);
                    n_state = S_CMD;
                end
            end
            S_CMD: begin
                n_cmd   = f_sat(-r_sum);
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_ovalid || o_out.ready) begin
                    n_o_cmd   = r_cmd;
                    n_o_prop  = r_rec;
                    n_o_integ = r_integ;
                    n_o_deriv = r_deriv;
                    n_ovalid  = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_start  <= 1'b0;
            r_ovalid <= 1'b0;
            r_integ  <= '0;
            r_prev   <= '0;
            r_rec    <= '0;
            r_deriv  <= '0;
        end else begin
            r_state  <= n_state;
            r_start  <= n_start;
            r_ovalid <= n_ovalid;
            r_integ  <= n_integ;
            r_prev   <= n_prev;
            r_rec    <= n_rec;
            r_deriv  <= n_deriv;
        end
        r_kind    <= n_kind;
        r_err     <= n_err;
        r_dt      <= n_dt;
        r_lim     <= n_lim;
        r_cmd     <= n_cmd;
        r_sum     <= n_sum;
        r_o_cmd   <= n_o_cmd;
        r_o_prop  <= n_o_prop;
        r_o_integ <= n_o_integ;
        r_o_deriv <= n_o_deriv;
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_ovalid;
    assign o_out.command     = r_o_cmd;
    assign o_out.prop_error  = r_o_prop;
    assign o_out.integ_error = r_o_integ;
    assign o_out.deriv_error = r_o_deriv;

    // One item at a time: the cycle after an accept the block is busy.
    `PIDC_ASSERT_NXT(a_one_item, i_clk, i_rst_n, i_in.valid && i_in.ready, !i_in.ready)
    // The arithmetic unit only reports completion while a compute step waits for it.
    `PIDC_ASSERT_IMP(a_done_in_step, i_clk, i_rst_n, w_done, r_state == S_PMUL || r_state == S_IINC || r_state == S_IMUL || r_state == S_CDIV || r_state == S_DDIV || r_state == S_DMUL)
    // A clear item leaves all controller state at zero.
    `PIDC_ASSERT_NXT(a_clear, i_clk, i_rst_n, i_in.valid && i_in.ready && i_in.kind == pidc_pkg::KIND_CLEAR, r_integ == '0 && r_prev == '0 && r_rec == '0 && r_deriv == '0)
    // A zero time step or invalid input never starts the arithmetic unit.
    `PIDC_ASSERT_NXT(a_suppress, i_clk, i_rst_n, i_in.valid && i_in.ready && (i_in.time_step == '0 || i_in.input_invalid), r_state == S_DONE && !r_start)

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench of pid_controller_step_top: random-paced item traffic, APB gain writes.
// Depends on pidc_pkg, pidc_in_if, pidc_out_if and the RTL of the block.
module tb_top;

    typedef logic signed [31:0]  t_q;
    typedef logic signed [127:0] t_wide;

    typedef struct {
        pidc_pkg::t_kind kind;
        t_q              err;
        t_q              rate;
        logic [31:0]     dt;
        logic            invalid;
    } t_pid_item;

    typedef struct {
        t_q command;
        t_q prop_error;
        t_q integ_error;
        t_q deriv_error;
    } t_pid_result;

    typedef struct {
        t_q prop;
        t_q integ;
        t_q deriv;
        t_q lim_hi;
        t_q lim_lo;
    } t_pid_gains;

    localparam int FRAC          = 16;
    localparam t_q Q_MAX         = 32'sh7FFF_FFFF;
    localparam t_q Q_MIN         = 32'sh8000_0000;
    localparam t_q ONE           = 32'sh0001_0000;
    localparam int NUM_PHASES    = 7;
    localparam int PHASE_ITEMS   = 121;
    localparam int STALL_LIMIT   = 20000;
    localparam int LONG_HOLD     = 1500;
    localparam int HOLD_AFTER    = 300;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [4:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    pidc_in_if  #(.DATA_WIDTH(32)) in_if ();
    pidc_out_if #(.DATA_WIDTH(32)) out_if ();

    pid_controller_step_top #(
        .DATA_WIDTH(32),
        .FRAC_BITS (FRAC)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    // Controller state and gain registers as the block should hold them.
    t_q integral_q   = '0;
    t_q prev_err_q   = '0;
    t_q rec_err_q    = '0;
    t_q deriv_val_q  = '0;
    t_q prop_gain_q  = '0;
    t_q integ_gain_q = '0;
    t_q deriv_gain_q = '0;
    t_q integ_max_q  = '0;
    t_q integ_min_q  = '0;

    t_pid_item   pid_items_pending[$];
    t_pid_result pid_outputs_due[$];

    bit in_fired;
    bit out_fired;
    int items_sent;
    int results_checked;
    int clamp_count;
    int suppressed_count;
    int fail_count;
    int stall_cycles;
    int gap_left;
    int burst_left;
    int hold_left;
    bit hold_done;
    int ready_mode;
    int ready_left;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_q sat_q(t_wide v);
        if (v > t_wide'(Q_MAX)) return Q_MAX;
        if (v < t_wide'(Q_MIN)) return Q_MIN;
        return v[31:0];
    endfunction

    function automatic t_wide mul_q(t_q a, t_q b);
        return (t_wide'(a) * t_wide'(b)) >>> FRAC;
    endfunction

    // Integral value that reproduces a clamped term; with zero gain it runs to the rail (zero for a zero limit).
    function automatic t_q integ_from_limit(t_q limit);
        if (integ_gain_q == 0) begin
            if (limit == 0) return '0;
            return (limit < 0) ? Q_MIN : Q_MAX;
        end
        return sat_q((t_wide'(limit) <<< FRAC) / t_wide'(integ_gain_q));
    endfunction

    function automatic t_pid_result next_pid_outputs(t_pid_item it);
        t_pid_result r;
        t_wide       p_term;
        t_wide       i_term;
        t_wide       d_term;
        t_wide       inc;
        r.command = '0;
        case (it.kind)
            pidc_pkg::KIND_CLEAR: begin
                integral_q  = '0;
                prev_err_q  = '0;
                rec_err_q   = '0;
                deriv_val_q = '0;
            end
            pidc_pkg::KIND_UPD_CALC, pidc_pkg::KIND_UPD_RATE: begin
                rec_err_q = it.err;
                if (it.kind == pidc_pkg::KIND_UPD_RATE) deriv_val_q = it.rate;
                if (it.dt != 0 && !it.invalid) begin
                    p_term     = mul_q(prop_gain_q, it.err);
                    inc        = (t_wide'({96'b0, it.dt}) * t_wide'(it.err)) >>> FRAC;
                    integral_q = sat_q(t_wide'(integral_q) + inc);
                    i_term     = mul_q(integ_gain_q, integral_q);
                    // The upper limit wins when the limits are inverted.
                    if (i_term > t_wide'(integ_max_q)) begin
                        i_term     = t_wide'(integ_max_q);
                        integral_q = integ_from_limit(integ_max_q);
                        clamp_count++;
                    end else if (i_term < t_wide'(integ_min_q)) begin
                        i_term     = t_wide'(integ_min_q);
                        integral_q = integ_from_limit(integ_min_q);
                        clamp_count++;
                    end
                    if (it.kind == pidc_pkg::KIND_UPD_CALC) begin
                        deriv_val_q = sat_q(((t_wide'(it.err) - t_wide'(prev_err_q)) <<< FRAC)
                                            / t_wide'({96'b0, it.dt}));
                        prev_err_q  = it.err;
                    end
                    d_term    = mul_q(deriv_gain_q, deriv_val_q);
                    r.command = sat_q(-(p_term + i_term + d_term));
                end else begin
                    suppressed_count++;
                end
            end
            default: ;
        endcase
        r.prop_error  = rec_err_q;
        r.integ_error = integral_q;
        r.deriv_error = deriv_val_q;
        return r;
    endfunction

    function automatic void check_field(string fname, t_q want, t_q got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
        end
    endfunction

    function automatic t_q small_q(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic t_pid_item mk_item(pidc_pkg::t_kind kind, t_q err, t_q rate,
                                          logic [31:0] dt, logic invalid);
        t_pid_item it;
        it.kind    = kind;
        it.err     = err;
        it.rate    = rate;
        it.dt      = dt;
        it.invalid = invalid;
        return it;
    endfunction

    // Mostly live updates with moderate values so the arithmetic stays off the rails.
    function automatic t_pid_item random_item();
        t_pid_item it;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)       it.kind = pidc_pkg::KIND_CLEAR;
        else if (pick < 7)  it.kind = pidc_pkg::KIND_NONE;
        else if (pick < 55) it.kind = pidc_pkg::KIND_UPD_CALC;
        else                it.kind = pidc_pkg::KIND_UPD_RATE;
        it.err  = ($urandom_range(0, 2) == 0) ? t_q'($urandom) : small_q(8 * ONE);
        it.rate = ($urandom_range(0, 2) == 0) ? t_q'($urandom) : small_q(8 * ONE);
        pick = $urandom_range(0, 19);
        if (pick == 0)      it.dt = '0;
        else if (pick == 1) it.dt = $urandom;
        else if (pick == 2) it.dt = 32'd1;
        else                it.dt = $urandom_range(1, 2 * ONE);
        it.invalid = ($urandom_range(0, 15) == 0);
        return it;
    endfunction

    function automatic t_pid_gains phase_gains(int ph);
        t_pid_gains g;
        g.prop   = small_q(4 * ONE);
        g.integ  = small_q(2 * ONE);
        g.deriv  = small_q(ONE);
        g.lim_hi = $urandom_range(ONE, 50 * ONE);
        g.lim_lo = -t_q'($urandom_range(ONE, 50 * ONE));
        case (ph)
            1: g = '{Q_MAX, Q_MIN, Q_MAX, Q_MAX, Q_MIN};
            2: begin
                g.integ  = '0;
                g.deriv  = Q_MIN;
                g.lim_hi = -t_q'($urandom_range(1, 10 * ONE));
                g.lim_lo = Q_MIN;
            end
            3: begin
                g.integ  = '0;
                g.lim_hi = Q_MAX;
                g.lim_lo = $urandom_range(1, 10 * ONE);
            end
            4: g = '{t_q'($urandom), t_q'($urandom), t_q'($urandom), t_q'($urandom),
                     t_q'($urandom)};
            5: begin
                g.deriv  = '0;
                g.lim_hi = -ONE;
                g.lim_lo = ONE;
            end
            6: begin
                g.prop   = '0;
                g.lim_hi = ONE / 2;
                g.lim_lo = -(ONE / 2);
            end
            default: ;
        endcase
        return g;
    endfunction

    task automatic reg_write(pidc_pkg::t_reg_idx idx, t_q value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            pidc_pkg::REG_PROP_GAIN:  prop_gain_q  = value;
            pidc_pkg::REG_INTEG_GAIN: integ_gain_q = value;
            pidc_pkg::REG_DERIV_GAIN: deriv_gain_q = value;
            pidc_pkg::REG_INTEG_MAX:  integ_max_q  = value;
            pidc_pkg::REG_INTEG_MIN:  integ_min_q  = value;
            default: ;
        endcase
    endtask

    task automatic apply_gains(t_pid_gains g);
        reg_write(pidc_pkg::REG_PROP_GAIN, g.prop);
        reg_write(pidc_pkg::REG_INTEG_GAIN, g.integ);
        reg_write(pidc_pkg::REG_DERIV_GAIN, g.deriv);
        reg_write(pidc_pkg::REG_INTEG_MAX, g.lim_hi);
        reg_write(pidc_pkg::REG_INTEG_MIN, g.lim_lo);
    endtask

    // Every item yields a result, so an empty expectation queue means the block is idle.
    task automatic wait_idle();
        @(negedge i_clk);
        while (pid_items_pending.size() != 0 || in_if.valid || pid_outputs_due.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin : sender
        t_pid_item nxt;
        if (!i_rst_n) begin
            in_if.valid         <= 1'b0;
            in_if.kind          <= pidc_pkg::KIND_UPD_CALC;
            in_if.error_in      <= '0;
            in_if.error_rate    <= '0;
            in_if.time_step     <= '0;
            in_if.input_invalid <= 1'b0;
        end else if (!in_if.valid || in_fired) begin
            if (gap_left > 0) begin
                gap_left--;
                in_if.valid <= 1'b0;
            end else if (pid_items_pending.size() > 0) begin
                nxt = pid_items_pending.pop_front();
                in_if.kind          <= nxt.kind;
                in_if.error_in      <= nxt.err;
                in_if.error_rate    <= nxt.rate;
                in_if.time_step     <= nxt.dt;
                in_if.input_invalid <= nxt.invalid;
                in_if.valid         <= 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 15);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
                end
            end else begin
                in_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : receiver
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (!hold_done && results_checked >= HOLD_AFTER) begin
                hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_if.ready <= 1'b0;
            end else begin
                if (ready_left == 0) begin
                    ready_mode = $urandom_range(0, 3);
                    ready_left = $urandom_range(16, 96);
                end
                ready_left--;
                case (ready_mode)
                    0:       out_if.ready <= 1'b1;
                    1:       out_if.ready <= ($urandom_range(0, 1) == 1);
                    2:       out_if.ready <= ($urandom_range(0, 7) == 0);
                    default: out_if.ready <= ($urandom_range(0, 3) != 0);
                endcase
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_pid_item   taken;
        t_pid_result want;
        in_fired  = in_if.valid && in_if.ready;
        out_fired = out_if.valid && out_if.ready;
        if (i_rst_n) begin
            if (in_fired) begin
                taken = mk_item(pidc_pkg::t_kind'(in_if.kind), in_if.error_in, in_if.error_rate,
                                in_if.time_step, in_if.input_invalid);
                pid_outputs_due.push_back(next_pid_outputs(taken));
                items_sent++;
            end
            if (out_fired) begin
                if (pid_outputs_due.size() == 0) begin
                    fail_count++;
                    $display("%0t: result with no item outstanding, command %h", $time,
                             out_if.command);
                end else begin
                    want = pid_outputs_due.pop_front();
                    check_field("command", want.command, out_if.command);
                    check_field("prop_error", want.prop_error, out_if.prop_error);
                    check_field("integ_error", want.integ_error, out_if.integ_error);
                    check_field("deriv_error", want.deriv_error, out_if.deriv_error);
                    results_checked++;
                end
            end
            if (in_fired || out_fired) stall_cycles = 0;
            else stall_cycles++;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, stall_cycles);
                $display("summary: stopped after %0d items and %0d checked results",
                         items_sent, results_checked);
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin : stimulus
        t_pid_gains g;
        i_rst_n = 1'b0;
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = '0;
        pwdata  = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: P = 1.0, I = 0.5, D = 0.25, integral term within +/-10.0.
        g = '{ONE, ONE / 2, ONE / 4, 10 * ONE, -10 * ONE};
        apply_gains(g);
        pid_items_pending.push_back(mk_item(pidc_pkg::KIND_UPD_CALC, '0, '0, ONE, 1'b0));
        pid_items_pending.push_back(mk_item(pidc_pkg::KIND_UPD_CALC, ONE, '0, ONE, 1'b0));
        pid_items_pending.push_back(mk_item(pidc_pkg::KIND_UPD_CALC, Q_MAX, '0, ONE, 1'b0));
        pid_items_pending.push_back(mk_item(pidc_pkg::KIND_UPD_CALC, Q_MIN, '0, 32'hFFFF_FFFF,
                                            1'b0));
        pid_items_pending.push_back(mk_item(pidc_pkg::KIND_UPD_RATE, ONE, Q_MAX, ONE, 1'b0));
        pid_items_pending.push_back(mk_item(pidc_pkg::KIND_UPD_RATE, -ONE, Q_MIN, ONE, 1'b0));
        pid_items_pending.push_back(mk_item(pidc_pkg::KIND_UPD_CALC, 5 * ONE, '0, '0, 1'b0));
        pid_items_pending.push_back(mk_item(pidc_pkg::KIND_UPD_RATE, 3 * ONE, 7 * ONE, '0,
                                            1'b0));
        pid_items_pending.push_back(mk_item(pidc_pkg::KIND_UPD_CALC, 2 * ONE, '0, ONE, 1'b1));
        pid_items_pending.push_back(mk_item(pidc_pkg::KIND_UPD_RATE, ONE, ONE, ONE, 1'b1));
        pid_items_pending.push_back(mk_item(pidc_pkg::KIND_NONE, $urandom, $urandom, $urandom,
                                            1'b1));
        pid_items_pending.push_back(mk_item(pidc_pkg::KIND_CLEAR, $urandom, $urandom, $urandom,
                                            1'b0));
        // Push the integral over the upper limit, then under the lower one.
        pid_items_pending.push_back(mk_item(pidc_pkg::KIND_UPD_CALC, 100 * ONE, '0, ONE, 1'b0));
        pid_items_pending.push_back(mk_item(pidc_pkg::KIND_UPD_CALC, -300 * ONE, '0, ONE,
                                            1'b0));
        // The smallest time step drives the formed derivative to the rail.
        pid_items_pending.push_back(mk_item(pidc_pkg::KIND_UPD_CALC, Q_MAX, '0, 32'd1, 1'b0));
        pid_items_pending.push_back(mk_item(pidc_pkg::KIND_UPD_RATE, '0, '0, 32'hFFFF_FFFF,
                                            1'b0));
        pid_items_pending.push_back(mk_item(pidc_pkg::KIND_CLEAR, '0, '0, '0, 1'b0));
        wait_idle();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            apply_gains(phase_gains(ph));
            repeat (PHASE_ITEMS) pid_items_pending.push_back(random_item());
            wait_idle();
        end

        repeat (200) @(negedge i_clk);
        if (pid_outputs_due.size() != 0) begin
            fail_count++;
            $display("%0t: %0d expected results never arrived", $time, pid_outputs_due.size());
        end
        $display("summary: %0d items over %0d gain settings, %0d results checked",
                 items_sent, NUM_PHASES + 1, results_checked);
        $display("summary: %0d integral clamps, %0d suppressed updates, %0d failures",
                 clamp_count, suppressed_count, fail_count);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+src
src/pidc_pkg.sv
src/pidc_in_if.sv
src/pidc_out_if.sv
src/pidc_mdu.sv
src/pidc_regs.sv
src/pid_controller_step_top.sv
tb/tb_top.sv
